FILE: hw/rtl/pfa_pkg.sv
// Package with the request, response and configuration types of the page frame allocator.
`timescale 1ns / 1ps

package pfa_pkg;

  localparam int MAX_FRAMES = 64;
  localparam int PAGE_BITS  = 20;
  localparam int FRAME_W    = $clog2(MAX_FRAMES);
  localparam int CNT_W      = 7;
  localparam logic [CNT_W-1:0] FRAMES_RESET = CNT_W'(MAX_FRAMES);

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_RELEASE = 3'd1,
    CMD_LOOKUP  = 3'd2,
    CMD_QUERY   = 3'd3,
    CMD_CLEAR   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK           = 3'd0,
    STAT_MAPPED       = 3'd1,
    STAT_FULL         = 3'd2,
    STAT_BAD_FRAME    = 3'd3,
    STAT_ALREADY_FREE = 3'd4,
    STAT_NOT_MAPPED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_QWAIT,
    S_DONE,
    S_RECOUNT
  } state_e;

  typedef struct packed {
    logic [2:0]           cmd;
    logic [PAGE_BITS-1:0] page_id;
    logic [FRAME_W-1:0]   frame_id;
  } req_t;

  typedef struct packed {
    logic                 ok;
    logic [2:0]           status;
    logic [FRAME_W-1:0]   frame_out;
    logic                 frame_occupied;
    logic [PAGE_BITS-1:0] frame_page;
    logic [CNT_W-1:0]     allocated_count;
    logic [CNT_W-1:0]     free_count;
  } rsp_t;

  typedef struct packed {
    logic             we;
    logic [CNT_W-1:0] frames_d;
    logic [CNT_W-1:0] frames_q;
  } cfg_t;

endpackage

FILE: hw/rtl/page_frame_allocator.sv
// Page frame allocator top level: configuration register, sequencer and output register.
// Usage:
// A request on in_req_i is taken when in_valid_i is high and in_stall_o is low.
// Every request not cut off by a write on cfg_we_i gives exactly one response on
// out_rsp_o, held with out_valid_o until a cycle in which out_stall_i is low.
// Allocate and lookup walk the page RAM one frame per cycle and stop at the first match;
// query reads the page RAM for one frame, while release, clear and unused commands
// answer without a read. The next request is taken in the cycle after the response
// is captured, so a new request never enters before the last response has reached the
// response register. The walk over the single read port of the page RAM limits how
// often allocate and lookup can repeat.
// The response register lets a new request enter while the last response waits.
// A write on cfg_we_i sets the frame count (values above 64 count as 64), frees
// frames at or above it and then recounts the occupied marks, during which
// in_stall_o stays high.
// After reset all frames are free, the frame count is 64 and no response is pending.
// A stalled response holds its value; the sequencer waits for the response register.
`timescale 1ns / 1ps

module page_frame_allocator
  import pfa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  req_t             in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rsp_t             out_rsp_o,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i
);

  logic [CNT_W-1:0] frames_q, frames_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q;
  cfg_t             cfg;
  logic             res_valid;
  logic             res_stall;
  rsp_t             res;

  always_comb begin
    frames_d = frames_q;
    if (cfg_we_i) begin
      frames_d = (cfg_wdata_i > CNT_W'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : cfg_wdata_i;
    end
  end

  assign cfg.we       = cfg_we_i;
  assign cfg.frames_d = frames_d;
  assign cfg.frames_q = frames_q;

  pfa_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .cfg_i      (cfg),
    .res_valid_o(res_valid),
    .res_stall_i(res_stall),
    .res_o      (res)
  );

  assign res_stall   = out_valid_q && out_stall_i;
  assign out_valid_d = (res_valid && !res_stall) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q    <= FRAMES_RESET;
      out_valid_q <= 1'b0;
    end else begin
      frames_q    <= frames_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !res_stall) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

FILE: hw/rtl/pfa_ram.sv
// Generic RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module pfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pfa_core.sv
// Command sequencer with the occupied marks, the allocation counter and the page RAM.
`timescale 1ns / 1ps

module pfa_core
  import pfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_req_i,
  input  cfg_t cfg_i,
  output logic res_valid_o,
  input  logic res_stall_i,
  output rsp_t res_o
);

  state_e state_q, state_d;
  req_t   req_q, req_d;
  rsp_t   res_q, res_d;
  logic [FRAME_W-1:0]    idx_q, idx_d;
  logic [FRAME_W-1:0]    free_idx_q, free_idx_d;
  logic                  free_found_q, free_found_d;
  logic [CNT_W-1:0]      rc_cnt_q, rc_cnt_d;
  logic [CNT_W-1:0]      alloc_q, alloc_d;
  logic [MAX_FRAMES-1:0] marks_q, marks_d;

  logic [MAX_FRAMES-1:0] keep_mask;
  logic [MAX_FRAMES-1:0] valid_mask;
  logic                  ram_we;
  logic [FRAME_W-1:0]    ram_waddr;
  logic [FRAME_W-1:0]    ram_raddr;
  logic [PAGE_BITS-1:0]  ram_rdata;
  logic                  hit;
  logic                  last;
  logic                  fid_valid;
  logic [FRAME_W-1:0]    fidx;

  pfa_ram #(
    .WIDTH(PAGE_BITS),
    .DEPTH(MAX_FRAMES)
  ) u_page_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(req_q.page_id),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    for (int f = 0; f < MAX_FRAMES; f++) begin
      keep_mask[f]  = CNT_W'(f) < cfg_i.frames_d;
      valid_mask[f] = CNT_W'(f) < cfg_i.frames_q;
    end
  end

  assign hit       = marks_q[idx_q] && (ram_rdata == req_q.page_id);
  assign last      = CNT_W'(idx_q) == (cfg_i.frames_q - CNT_W'(1));
  assign fid_valid = CNT_W'(in_req_i.frame_id) < cfg_i.frames_q;
  assign fidx      = free_found_q ? free_idx_q : idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      marks_q      <= '0;
      alloc_q      <= '0;
      idx_q        <= '0;
      free_found_q <= 1'b0;
      rc_cnt_q     <= '0;
    end else begin
      state_q      <= state_d;
      marks_q      <= marks_d;
      alloc_q      <= alloc_d;
      idx_q        <= idx_d;
      free_found_q <= free_found_d;
      rc_cnt_q     <= rc_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    free_idx_q <= free_idx_d;
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    res_d        = res_q;
    idx_d        = idx_q;
    free_idx_d   = free_idx_q;
    free_found_d = free_found_q;
    rc_cnt_d     = rc_cnt_q;
    alloc_d      = alloc_q;
    marks_d      = marks_q;
    ram_we       = 1'b0;
    ram_waddr    = fidx;
    ram_raddr    = idx_q + FRAME_W'(1);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d        = in_req_i;
          res_d        = '0;
          idx_d        = '0;
          free_found_d = 1'b0;
          state_d      = S_DONE;
          unique case (cmd_e'(in_req_i.cmd))
            CMD_ALLOC, CMD_LOOKUP: begin
              if (cfg_i.frames_q == '0) begin
                res_d.status = (cmd_e'(in_req_i.cmd) == CMD_ALLOC) ? STAT_FULL
                                                                   : STAT_NOT_MAPPED;
              end else begin
                ram_raddr = '0;
                state_d   = S_SCAN;
              end
            end
            CMD_RELEASE: begin
              if (!fid_valid) begin
                res_d.status = STAT_BAD_FRAME;
              end else if (!marks_q[in_req_i.frame_id]) begin
                res_d.status = STAT_ALREADY_FREE;
              end else begin
                marks_d[in_req_i.frame_id] = 1'b0;
                alloc_d  = alloc_q - CNT_W'(1);
                res_d.ok = 1'b1;
              end
            end
            CMD_QUERY: begin
              if (!fid_valid) begin
                res_d.status = STAT_BAD_FRAME;
              end else begin
                ram_raddr = in_req_i.frame_id;
                state_d   = S_QWAIT;
              end
            end
            CMD_CLEAR: begin
              marks_d  = '0;
              alloc_d  = '0;
              res_d.ok = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (cmd_e'(req_q.cmd) == CMD_ALLOC) begin
            res_d.status = STAT_MAPPED;
          end else begin
            res_d.ok        = 1'b1;
            res_d.frame_out = idx_q;
          end
          state_d = S_DONE;
        end else if (last) begin
          if (cmd_e'(req_q.cmd) == CMD_ALLOC) begin
            if (free_found_q || !marks_q[idx_q]) begin
              ram_we          = 1'b1;
              marks_d[fidx]   = 1'b1;
              alloc_d         = alloc_q + CNT_W'(1);
              res_d.ok        = 1'b1;
              res_d.frame_out = fidx;
            end else begin
              res_d.status = STAT_FULL;
            end
          end else begin
            res_d.status = STAT_NOT_MAPPED;
          end
          state_d = S_DONE;
        end else begin
          if (!marks_q[idx_q] && !free_found_q) begin
            free_idx_d   = idx_q;
            free_found_d = 1'b1;
          end
          idx_d = idx_q + FRAME_W'(1);
        end
      end
      S_QWAIT: begin
        res_d.ok             = 1'b1;
        res_d.frame_occupied = marks_q[req_q.frame_id];
        res_d.frame_page     = marks_q[req_q.frame_id] ? ram_rdata : '0;
        state_d              = S_DONE;
      end
      S_DONE: begin
        if (!res_stall_i) begin
          state_d = S_IDLE;
        end
      end
      S_RECOUNT: begin
        rc_cnt_d = rc_cnt_q + CNT_W'(marks_q[idx_q]);
        idx_d    = idx_q + FRAME_W'(1);
        if (idx_q == FRAME_W'(MAX_FRAMES - 1)) begin
          alloc_d = rc_cnt_d;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (cfg_i.we) begin
      marks_d  = marks_q & keep_mask;
      idx_d    = '0;
      rc_cnt_d = '0;
      state_d  = S_RECOUNT;
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign res_valid_o = state_q == S_DONE;

  always_comb begin
    res_o                 = res_q;
    res_o.allocated_count = alloc_q;
    res_o.free_count      = (cfg_i.frames_q >= alloc_q) ? (cfg_i.frames_q - alloc_q) : '0;
  end

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> ($countones(marks_q) == int'(alloc_q)))
    else $error("allocation count differs from the occupied marks");

  a_no_marks_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (marks_q & ~valid_mask) == '0)
    else $error("occupied mark at or above the frame count");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (CNT_W'(idx_q) < cfg_i.frames_q))
    else $error("scan index beyond the frame count");

  a_idle_within: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (alloc_q <= cfg_i.frames_q))
    else $error("allocated count above the frame count");

endmodule
